// File: design/mra_pkg.sv
`timescale 1ns / 1ps
package mra_pkg;

  localparam int SAMPLE_PORT_W = 16;
  localparam int EXT_W         = 17;
  localparam int SUM_W         = 33;
  localparam int SQ_W          = 47;
  localparam int CNT_W         = 17;
  localparam int OUT_W         = 24;
  localparam int DIV_W         = 63;
  localparam int DIVISOR_W     = 17;
  localparam int RAD_W         = 64;
  localparam int ROOT_W        = 32;
  localparam int MSQ_W         = 47;

  localparam logic [OUT_W-1:0] MEAN_POS_MAX = 24'h7FFFFF;
  localparam logic [OUT_W-1:0] MEAN_NEG_MIN = 24'h800000;
  localparam logic [OUT_W-1:0] RMS_MAX      = 24'hFFFFFF;

  typedef enum logic [5:0] {
    ST_ACC      = 6'b000001,
    ST_LD_MEAN  = 6'b000010,
    ST_DIV_MEAN = 6'b000100,
    ST_LD_SQ    = 6'b001000,
    ST_DIV_SQ   = 6'b010000,
    ST_SQRT     = 6'b100000
  } state_e;

  typedef struct packed {
    logic accum;
    logic load_mean;
    logic capture_mean;
    logic load_sq;
    logic load_sqrt;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic div_done;
    logic sqrt_done;
  } status_t;

endpackage

// File: design/mra_div.sv
`timescale 1ns / 1ps
module mra_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [mra_pkg::DIV_W-1:0]     dividend_i,
  input  logic [mra_pkg::DIVISOR_W-1:0] divisor_i,
  output logic [mra_pkg::DIV_W-1:0]     quotient_o,
  output logic [mra_pkg::DIVISOR_W-1:0] remainder_o,
  output logic                          done_o
);
  import mra_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic                 busy_q;
  logic                 done_q;
  logic [CW-1:0]        cnt_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (load_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DIV_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

// File: design/mra_sqrt.sv
`timescale 1ns / 1ps
module mra_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [mra_pkg::RAD_W-1:0]  radicand_i,
  output logic [mra_pkg::ROOT_W-1:0] root_o,
  output logic                       done_o
);
  import mra_pkg::*;

  localparam int CW  = $clog2(ROOT_W);
  localparam int REM = ROOT_W + 2;

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM-1:0]    rem_q;
  logic [REM+1:0]    shifted;
  logic [REM+1:0]    trial;
  logic [REM+1:0]    diff;
  logic              ge;

  // digit-by-digit root, two radicand bits per cycle
  assign shifted = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = shifted >= trial;
  assign diff    = shifted - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (load_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ROOT_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= ge ? diff[REM-1:0] : shifted[REM-1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// File: design/mra_ctrl.sv
`timescale 1ns / 1ps
module mra_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  mra_pkg::status_t status_i,
  output mra_pkg::cmd_t    cmd_o,
  output logic             busy
);
  import mra_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_ACC: begin
        if (start) begin
          cmd_o.accum = 1'b1;
          if (status_i.close) begin
            state_d = ST_LD_MEAN;
          end
        end
      end
      ST_LD_MEAN: begin
        cmd_o.load_mean = 1'b1;
        state_d         = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        if (status_i.div_done) begin
          cmd_o.capture_mean = 1'b1;
          state_d            = ST_LD_SQ;
        end
      end
      ST_LD_SQ: begin
        cmd_o.load_sq = 1'b1;
        state_d       = ST_DIV_SQ;
      end
      ST_DIV_SQ: begin
        if (status_i.div_done) begin
          cmd_o.load_sqrt = 1'b1;
          state_d         = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (status_i.sqrt_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_ACC);

`ifndef SYNTHESIS
  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ST_DIV_MEAN) || (state_q == ST_DIV_SQ))
    else $error("divider finished outside a divide phase");
  a_sqrt_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.sqrt_done |-> (state_q == ST_SQRT))
    else $error("root unit finished outside the root phase");
  a_finish_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == ST_ACC))
    else $error("controller not idle after finishing a set");
  a_one_unit_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_mean, cmd_o.load_sq, cmd_o.load_sqrt, cmd_o.finish}))
    else $error("conflicting unit commands");
`endif

endmodule

// File: design/mra_datapath.sv
`timescale 1ns / 1ps
module mra_datapath #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_SAMPLES  = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mra_pkg::cmd_t                  cmd_i,
  output mra_pkg::status_t               status_o,
  input  logic [mra_pkg::SAMPLE_PORT_W-1:0] sample_i,
  input  logic                           last_sample_i,
  output logic [mra_pkg::OUT_W-1:0]      mean_value_o,
  output logic [mra_pkg::OUT_W-1:0]      rms_value_o,
  output logic [mra_pkg::CNT_W-1:0]      sample_count_o,
  output logic                           done_o
);
  import mra_pkg::*;

  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int LIMIT_INT = (MAX_SAMPLES < CNT_MAX) ? MAX_SAMPLES : CNT_MAX;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LIMIT_INT);
  localparam int  EFF_W     = (SAMPLE_WIDTH < SAMPLE_PORT_W) ? SAMPLE_WIDTH : SAMPLE_PORT_W;
  localparam bit  SIGN_EXT  = (SAMPLE_WIDTH <= SAMPLE_PORT_W);

  logic [SUM_W-1:0]       sum_q;
  logic [SQ_W-1:0]        sq_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [OUT_W-1:0]       mean_q;
  logic [MSQ_W-1:0]       msq_q;
  logic [OUT_W-1:0]       rms_q;
  logic [CNT_W-1:0]       count_out_q;
  logic                   done_q;

  logic signed [EXT_W-1:0]   ext;
  logic signed [2*EXT_W-1:0] ext_sq;
  logic [CNT_W:0]            cnt_inc;

  logic                  sum_neg;
  logic [SUM_W-1:0]      sum_mag;
  logic                  div_load;
  logic [DIV_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      quotient;
  logic [DIVISOR_W-1:0]  remainder;
  logic                  div_done;
  logic [40:0]           q_adj;
  logic [OUT_W-1:0]      mean_d;
  logic signed [2*OUT_W-1:0] mean_sq;
  logic [DIV_W-1:0]      msq_ext;
  logic [DIV_W-1:0]      var_val;
  logic [ROOT_W-1:0]     root;
  logic                  sqrt_done;

  // take the low sample bits; sign-extend them when SAMPLE_WIDTH fits the port, else zero-extend
  always_comb begin
    ext = '0;
    for (int i = 0; i < EXT_W; i++) begin
      if (i < EFF_W) begin
        ext[i] = sample_i[i];
      end else if (SIGN_EXT) begin
        ext[i] = sample_i[EFF_W-1];
      end
    end
  end

  assign ext_sq  = ext * ext;
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;

  assign status_o.close     = last_sample_i || (cnt_inc >= {1'b0, LIMIT});
  assign status_o.div_done  = div_done;
  assign status_o.sqrt_done = sqrt_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      sq_q   <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.accum) begin
        sum_q <= sum_q + {{(SUM_W-EXT_W){ext[EXT_W-1]}}, ext};
        sq_q  <= sq_q + {{(SQ_W-2*EXT_W){1'b0}}, ext_sq};
        cnt_q <= cnt_inc[CNT_W-1:0];
      end else if (cmd_i.finish) begin
        sum_q <= '0;
        sq_q  <= '0;
        cnt_q <= '0;
      end
    end
  end

  // one divider serves both the mean and the scaled mean of squares
  assign sum_neg      = sum_q[SUM_W-1];
  assign sum_mag      = sum_neg ? (~sum_q + 1'b1) : sum_q;
  assign div_load     = cmd_i.load_mean || cmd_i.load_sq;
  assign div_dividend = cmd_i.load_sq ? {sq_q, 16'h0000}
                                      : {{(DIV_W-SUM_W-8){1'b0}}, sum_mag, 8'h00};

  mra_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (div_load),
    .dividend_i  (div_dividend),
    .divisor_i   (cnt_q),
    .quotient_o  (quotient),
    .remainder_o (remainder),
    .done_o      (div_done)
  );

  // floor toward minus infinity, then saturate to 24 bits
  assign q_adj = quotient[40:0] + {40'd0, (sum_neg && (remainder != '0))};

  always_comb begin
    if (sum_neg) begin
      if (q_adj > 41'd8388608) begin
        mean_d = MEAN_NEG_MIN;
      end else begin
        mean_d = ~q_adj[OUT_W-1:0] + 1'b1;
      end
    end else if (quotient > DIV_W'(8388607)) begin
      mean_d = MEAN_POS_MAX;
    end else begin
      mean_d = quotient[OUT_W-1:0];
    end
  end

  assign mean_sq = $signed(mean_q) * $signed(mean_q);
  assign msq_ext = {{(DIV_W-MSQ_W){1'b0}}, msq_q};
  // clamp a negative variance to zero
  assign var_val = (quotient >= msq_ext) ? (quotient - msq_ext) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_mean) begin
      mean_q <= mean_d;
    end
    if (cmd_i.load_sq) begin
      msq_q <= mean_sq[MSQ_W-1:0];
    end
    if (cmd_i.finish) begin
      rms_q       <= (root > {{(ROOT_W-OUT_W){1'b0}}, RMS_MAX}) ? RMS_MAX : root[OUT_W-1:0];
      count_out_q <= cnt_q;
    end
  end

  mra_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (cmd_i.load_sqrt),
    .radicand_i ({1'b0, var_val}),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  assign mean_value_o   = mean_q;
  assign rms_value_o    = rms_q;
  assign sample_count_o = count_out_q;
  assign done_o         = done_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LIMIT)
    else $error("sample count ran past its limit");
  a_cleared_after_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cnt_q == '0) || $past(cmd_i.accum))
    else $error("accumulators not cleared after a set");
  a_result_nonzero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sample_count_o != '0))
    else $error("result for an empty set");
`endif

endmodule

// File: design/mean_rms_accumulator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// ------    ---------  ------------------------  -----------------------------------------
// sample    in         start high, busy low      sample_i[15:0], last_sample_i
// result    out        done_o, one cycle strobe  mean_value_o, rms_value_o, sample_count_o
//
// Each sample item is accumulated as it is taken; busy stays low until a set closes, so samples stream back to back.
// The item marked last (or the one that fills the set) raises busy while the shared restoring
// divider runs for the mean and then for the mean of squares, each after a load state, and then the root unit runs.
// done_o pulses in the cycle in which busy falls; a new item may be taken then.
// Reset (rst_ni low, asynchronous) clears the sums, the count and the controller.
// The receiver cannot stall; the mean holds until the next set's mean is captured, rms and count until its strobe.
module mean_rms_accumulator #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int MAX_SAMPLES  = 65536
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [mra_pkg::SAMPLE_PORT_W-1:0] sample_i,
  input  logic                              last_sample_i,
  output logic                              done_o,
  output logic [mra_pkg::OUT_W-1:0]         mean_value_o,
  output logic [mra_pkg::OUT_W-1:0]         rms_value_o,
  output logic [mra_pkg::CNT_W-1:0]         sample_count_o
);
  import mra_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: accumulate, divide twice, take the root, report.
  mra_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Accumulators, the shared divider, the root unit and the result registers.
  mra_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .MAX_SAMPLES  (MAX_SAMPLES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_i       (sample_i),
    .last_sample_i  (last_sample_i),
    .mean_value_o   (mean_value_o),
    .rms_value_o    (rms_value_o),
    .sample_count_o (sample_count_o),
    .done_o         (done_o)
  );

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) && !busy)
    else $error("result strobe without a finished set");
  a_no_back_to_back_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");
  a_busy_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for mean_rms_accumulator: stream sample items in, close sets on
// last_sample_i or on the set-length limit, and compare each result strobe against
// an in-bench model of the running mean / rms spread.
module tb_top;
  import mra_pkg::*;

  localparam int SET_LIMIT   = 65536;  // default MAX_SAMPLES, below the 17-bit count cap
  localparam int STALL_LIMIT = 2000;   // cycles with no item and no result
  localparam int DRAIN_WAIT  = 200;    // covers the close of a set plus the strobe
  localparam int N_ROWS      = 21;

  typedef struct packed {
    logic [OUT_W-1:0] mean;
    logic [OUT_W-1:0] rms;
    logic [CNT_W-1:0] cnt;
  } stats_t;

  typedef struct {
    logic [SAMPLE_PORT_W-1:0] smp;
    logic                     lst;
    int unsigned              reps;
    bit                       typed;
    logic [OUT_W-1:0]         mean;
    logic [OUT_W-1:0]         rms;
    logic [CNT_W-1:0]         cnt;
  } stim_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [SAMPLE_PORT_W-1:0] sample_i;
  logic                     last_sample_i;
  logic                     done_o;
  logic [OUT_W-1:0]         mean_value_o;
  logic [OUT_W-1:0]         rms_value_o;
  logic [CNT_W-1:0]         sample_count_o;

  // Model state of the open set
  logic [SUM_W-1:0] sum_acc;
  logic [SQ_W-1:0]  sq_acc;
  logic [CNT_W-1:0] cnt_acc;

  stats_t      pending_stats[$];
  stim_row_t   dir_rows[N_ROWS];
  int unsigned sender_idle_pct;
  int unsigned items_sent;
  int unsigned sets_checked;
  int unsigned errors;
  int unsigned stall_cycles;

  mean_rms_accumulator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_i       (sample_i),
    .last_sample_i  (last_sample_i),
    .done_o         (done_o),
    .mean_value_o   (mean_value_o),
    .rms_value_o    (rms_value_o),
    .sample_count_o (sample_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Fold one sample into the open set; on close, return the Q8 mean, Q8 rms and count,
  // then clear the set.
  function automatic bit fold_sample(input logic [SAMPLE_PORT_W-1:0] smp, input logic lst,
                                     output stats_t res);
    longint     s;
    longint     n;
    longint     num;
    longint     avg;
    longint     var_q;
    bit [63:0]  msq;
    bit [63:0]  root;
    bit [63:0]  trial;
    s       = longint'($signed(smp));
    sum_acc = sum_acc + SUM_W'(s);
    sq_acc  = sq_acc + SQ_W'(s * s);
    cnt_acc = cnt_acc + 1'b1;
    res     = '0;
    if (!lst && cnt_acc < SET_LIMIT) return 1'b0;
    n   = longint'(cnt_acc);
    num = longint'($signed(sum_acc)) * 256;
    // Division truncates toward zero; step down to floor for negative remainders.
    avg = num / n;
    if ((num % n) != 0 && num < 0) avg = avg - 1;
    if (avg > 8388607) avg = 8388607;
    if (avg < -8388608) avg = -8388608;
    msq   = 64'(sq_acc) << 16;
    msq   = msq / 64'(cnt_acc);
    var_q = longint'(msq) - avg * avg;
    if (var_q < 0) var_q = 0;
    // Bitwise integer root: keep each trial bit whose square still fits.
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= 64'(var_q)) root = trial;
    end
    res.mean = avg[OUT_W-1:0];
    res.rms  = (root > 64'hFFFFFF) ? RMS_MAX : root[OUT_W-1:0];
    res.cnt  = cnt_acc;
    sum_acc  = '0;
    sq_acc   = '0;
    cnt_acc  = '0;
    return 1'b1;
  endfunction

  // Offer one item, hold it until taken, then predict; idle afterwards at the set rate.
  task automatic send_sample(input logic [SAMPLE_PORT_W-1:0] smp, input logic lst,
                             input bit typed, input stats_t typed_res);
    stats_t pred;
    bit     closes;
    start         <= 1'b1;
    sample_i      <= smp;
    last_sample_i <= lst;
    do @(posedge clk_i); while (busy);
    closes = fold_sample(smp, lst, pred);
    if (closes || typed) pending_stats.push_back(typed ? typed_res : pred);
    items_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      // Drop start and put noise on the payload while idle.
      start         <= 1'b0;
      sample_i      <= SAMPLE_PORT_W'($urandom);
      last_sample_i <= 1'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Hold off the sender until every pending result has come out.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_PORT_W-1:0] draw_sample(input int unsigned mode,
                                                          input logic [SAMPLE_PORT_W-1:0] base);
    case (mode)
      0: return SAMPLE_PORT_W'($urandom);
      1: return SAMPLE_PORT_W'($urandom_range(16) - 8);
      2: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      default: return base + SAMPLE_PORT_W'($urandom_range(2)) - 16'd1;
    endcase
  endfunction

  // Send random sets until the phase has moved about item_goal items.
  task automatic run_sets(input int unsigned idle_pct, input int unsigned item_goal);
    int unsigned              first;
    int unsigned              len;
    int unsigned              mode;
    logic [SAMPLE_PORT_W-1:0] base;
    sender_idle_pct = idle_pct;
    first           = items_sent;
    while (items_sent - first < item_goal) begin
      // Mostly short sets so results come often; now and then a longer one.
      len  = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(1, 8);
      mode = $urandom_range(3);
      base = SAMPLE_PORT_W'($urandom);
      for (int unsigned i = 0; i < len; i++)
        send_sample(draw_sample(mode, base), i == len - 1, 1'b0, '0);
    end
    drain_results();
  endtask

  // Check each result strobe against the oldest prediction.
  always @(posedge clk_i) begin
    stats_t want;
    if (rst_ni && done_o) begin
      if (pending_stats.size() == 0) begin
        $error("result with no item pending: mean %h rms %h count %0d",
               mean_value_o, rms_value_o, sample_count_o);
        errors++;
      end else begin
        want = pending_stats.pop_front();
        sets_checked++;
        if (mean_value_o !== want.mean) begin
          $error("mean_value: expected %h, got %h", want.mean, mean_value_o);
          errors++;
        end
        if (rms_value_o !== want.rms) begin
          $error("rms_value: expected %h, got %h", want.rms, rms_value_o);
          errors++;
        end
        if (sample_count_o !== want.cnt) begin
          $error("sample_count: expected %0d, got %0d", want.cnt, sample_count_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    sample_i        = '0;
    last_sample_i   = 1'b0;
    sum_acc         = '0;
    sq_acc          = '0;
    cnt_acc         = '0;
    items_sent      = 0;
    sets_checked    = 0;
    errors          = 0;
    stall_cycles    = 0;
    sender_idle_pct = 34;

    // Directed rows: sample, last, repeat, typed?, mean, rms, count.
    // Typed expectations apply to the final repeat of a row.
    dir_rows = '{
      // single-sample sets at the extremes, right after reset
      '{16'h0000, 1'b1, 1,     1'b1, 24'h000000, 24'h0, 17'd1},
      '{16'h7FFF, 1'b1, 1,     1'b1, 24'h7FFF00, 24'h0, 17'd1},
      '{16'h8000, 1'b1, 1,     1'b1, 24'h800000, 24'h0, 17'd1},
      '{16'h0001, 1'b1, 1,     1'b1, 24'h000100, 24'h0, 17'd1},
      '{16'hFFFF, 1'b1, 1,     1'b1, 24'hFFFF00, 24'h0, 17'd1},
      // opposite extremes: mean just below zero, largest spread
      '{16'h7FFF, 1'b0, 1,     1'b0, 24'h0, 24'h0, 17'd0},
      '{16'h8000, 1'b1, 1,     1'b0, 24'h0, 24'h0, 17'd0},
      // alternating bit patterns
      '{16'h5555, 1'b0, 1,     1'b0, 24'h0, 24'h0, 17'd0},
      '{16'hAAAA, 1'b0, 1,     1'b0, 24'h0, 24'h0, 17'd0},
      '{16'h0003, 1'b1, 1,     1'b0, 24'h0, 24'h0, 17'd0},
      // negative mean with a remainder: floor, not truncation
      '{16'hFFFF, 1'b0, 2,     1'b0, 24'h0, 24'h0, 17'd0},
      '{16'h0000, 1'b1, 1,     1'b0, 24'h0, 24'h0, 17'd0},
      '{16'h7FFF, 1'b0, 1,     1'b0, 24'h0, 24'h0, 17'd0},
      '{16'h8000, 1'b0, 1,     1'b0, 24'h0, 24'h0, 17'd0},
      '{16'h7FFF, 1'b0, 1,     1'b0, 24'h0, 24'h0, 17'd0},
      '{16'h8000, 1'b1, 1,     1'b0, 24'h0, 24'h0, 17'd0},
      // floored mean squared beats the floored mean of squares: variance clamps to zero
      '{16'hFFFF, 1'b0, 299,   1'b0, 24'h0, 24'h0, 17'd0},
      '{16'h0000, 1'b1, 1,     1'b1, 24'hFFFF00, 24'h0, 17'd300},
      // full-length set closes on the limit with no last marker, sums at their peak
      '{16'h8000, 1'b0, 65535, 1'b0, 24'h0, 24'h0, 17'd0},
      '{16'h8000, 1'b0, 1,     1'b1, 24'h800000, 24'h0, 17'h10000},
      // the set after a forced close must start from clean sums
      '{16'h0001, 1'b1, 1,     1'b1, 24'h000100, 24'h0, 17'd1}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      for (int unsigned k = 0; k < dir_rows[r].reps; k++)
        send_sample(dir_rows[r].smp, dir_rows[r].lst,
                    dir_rows[r].typed && (k == dir_rows[r].reps - 1),
                    '{dir_rows[r].mean, dir_rows[r].rms, dir_rows[r].cnt});
    end
    drain_results();

    // Random sets: sender idles often, then heavily, then never.
    run_sets(34, 170);
    run_sets(60, 170);
    run_sets(0, 170);

    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Streamed %0d sample items and checked %0d closed sets, including a", items_sent,
             sets_checked);
    $display("full-length set, extreme samples and a clamped-variance set.");
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/mra_pkg.sv
design/mra_div.sv
design/mra_sqrt.sv
design/mra_ctrl.sv
design/mra_datapath.sv
design/mean_rms_accumulator.sv
bench/tb_top.sv
